[rtl/core/rgbhsv_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgbhsv_pkg;

   // Hue sector offsets on the 0..255 circle
   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

   // Number of quotient bits, one per divider cell
   localparam int unsigned QUO_BITS = 8;

   // Input pixel payload
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Result payload
   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_type;

   // One restoring-division lane: partial remainder, divisor, quotient so far
   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  den;
      logic [7:0]  quo;
   } div_lane_type;

   // Everything a pixel carries down the cell chain
   typedef struct packed {
      logic         valid;
      div_lane_type sat;
      div_lane_type hue;
      logic [7:0]   base;
      logic         neg;
      logic         black;
      logic [7:0]   brightness;
   } cell_type;

endpackage

`default_nettype wire

[rtl/core/rgb_to_hsv_pixel.sv]
// RGB to HSV pixel converter: front stage, eight divider cells, output register.
// Throughput: one pixel per cycle while the output is not stalled; each divider cell settles one quotient bit.
// Stages hold independently, so bubbles close up behind a stalled output.
// Reset (synchronous) empties every stage; the block holds no other state.
`default_nettype none

module rgb_to_hsv_pixel (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire rgbhsv_pkg::pixel_type req_pixel,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rgbhsv_pkg::hsv_type   rsp_pixel
);
   import rgbhsv_pkg::*;

   cell_type                pipe [QUO_BITS+1];
   logic [QUO_BITS+1:0]     ready;
   logic                    rsp_valid_ff;
   hsv_type                 rsp_data_ff;
   hsv_type                 rsp_data_in;
   logic [7:0]              hue_offset;

   // Stage ready chain: a stage moves when empty or when its successor moves
   always_comb begin
      ready[QUO_BITS+1] = !rsp_valid_ff || !rsp_stall;
      for (int k = QUO_BITS; k >= 0; k--) begin
         ready[k] = !pipe[k].valid || ready[k+1];
      end
   end

   assign req_stall = !ready[0];

   rgbhsv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (ready[0]),
      .pixel_valid (req_valid),
      .pixel       (req_pixel),
      .cell_out    (pipe[0])
   );

   // Divider chain, most significant quotient bit first
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_cell
      rgbhsv_div_cell #(
         .BIT (QUO_BITS - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (ready[k+1]),
         .cell_in  (pipe[k]),
         .cell_out (pipe[k+1])
      );
   end

   // Result assembly: black and grey pixels force zero fields
   always_comb begin
      hue_offset = pipe[QUO_BITS].neg ? 8'(-pipe[QUO_BITS].hue.quo)
                                      : pipe[QUO_BITS].hue.quo;
      rsp_data_in.brightness = pipe[QUO_BITS].brightness;
      if (pipe[QUO_BITS].black) begin
         rsp_data_in.saturation = 8'd0;
         rsp_data_in.hue        = 8'd0;
      end else begin
         rsp_data_in.saturation = pipe[QUO_BITS].sat.quo;
         if (pipe[QUO_BITS].sat.quo == 8'd0) begin
            rsp_data_in.hue = 8'd0;
         end else begin
            rsp_data_in.hue = pipe[QUO_BITS].base + hue_offset;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready[QUO_BITS+1]) begin
         rsp_valid_ff <= pipe[QUO_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[QUO_BITS+1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/rgbhsv_front.sv]
// Front stage: max/min search, chroma, brightness and division operands.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  pixel_valid,
   input  wire rgbhsv_pkg::pixel_type pixel,
   output      rgbhsv_pkg::cell_type  cell_out
);
   import rgbhsv_pkg::*;

   logic [7:0]  mx;
   logic [7:0]  mn;
   logic [7:0]  chroma;
   logic [8:0]  diff;
   logic [7:0]  diff_abs;
   logic [8:0]  mid_sum;
   cell_type    data_in;
   cell_type    data_ff;
   logic        valid_ff;

   // Channel extremes and sector selection; red wins ties, then green
   always_comb begin
      mx = pixel.red;
      if (pixel.green > mx) mx = pixel.green;
      if (pixel.blue > mx) mx = pixel.blue;
      mn = pixel.red;
      if (pixel.green < mn) mn = pixel.green;
      if (pixel.blue < mn) mn = pixel.blue;
      chroma  = mx - mn;
      mid_sum = {1'b0, mx} + {1'b0, mn};

      if (mx == pixel.red) begin
         data_in.base = HUE_BASE_RED;
         diff = {1'b0, pixel.green} - {1'b0, pixel.blue};
      end else if (mx == pixel.green) begin
         data_in.base = HUE_BASE_GREEN;
         diff = {1'b0, pixel.blue} - {1'b0, pixel.red};
      end else begin
         data_in.base = HUE_BASE_BLUE;
         diff = {1'b0, pixel.red} - {1'b0, pixel.green};
      end
      diff_abs = diff[8] ? 8'(-diff) : diff[7:0];

      data_in.valid      = pixel_valid;
      data_in.neg        = diff[8];
      data_in.black      = (mx == 8'd0);
      data_in.brightness = mid_sum[8:1];
      // 255 * chroma as (chroma << 8) - chroma
      data_in.sat.rem    = {chroma, 8'd0} - {8'd0, chroma};
      data_in.sat.den    = mx;
      data_in.sat.quo    = 8'd0;
      // 43 * |diff| = 32x + 8x + 2x + x
      data_in.hue.rem    = ({8'd0, diff_abs} << 5) + ({8'd0, diff_abs} << 3)
                         + ({8'd0, diff_abs} << 1) + {8'd0, diff_abs};
      data_in.hue.den    = chroma;
      data_in.hue.quo    = 8'd0;
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= data_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

[rtl/core/rgbhsv_div_cell.sv]
// One divider cell: resolves one quotient bit for both division lanes.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_div_cell #(
   parameter int unsigned BIT = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire rgbhsv_pkg::cell_type cell_in,
   output      rgbhsv_pkg::cell_type cell_out
);
   import rgbhsv_pkg::*;

   logic [15:0] sat_shift;
   logic [15:0] hue_shift;
   cell_type    data_in;
   cell_type    data_ff;
   logic        valid_ff;

   // Compare-subtract against the divisor weighted by this bit
   always_comb begin
      sat_shift = {8'd0, cell_in.sat.den} << BIT;
      hue_shift = {8'd0, cell_in.hue.den} << BIT;
      data_in   = cell_in;
      if (cell_in.sat.rem >= sat_shift) begin
         data_in.sat.rem      = cell_in.sat.rem - sat_shift;
         data_in.sat.quo[BIT] = 1'b1;
      end
      if (cell_in.hue.rem >= hue_shift) begin
         data_in.hue.rem      = cell_in.hue.rem - hue_shift;
         data_in.hue.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

[sim/rgb_to_hsv_pixel_test.sv]
// Self-checking bench for rgb_to_hsv_pixel: directed and random pixels, random bursts,
// output stalls and long hold-offs. Each result is checked against a built-in HSV predictor.
// Depends on rgbhsv_pkg (payload types, hue offsets) and the rgb_to_hsv_pixel RTL.

module rgb_to_hsv_pixel_test;
   import rgbhsv_pkg::*;

   localparam int SAT_SCALE   = 255;  // saturation full scale
   localparam int HUE_SPAN    = 43;   // hue steps per sector half
   localparam int RAND_PIXELS = 1500;
   localparam int DRAIN_CYCLES = 20;  // pipeline is 10 deep
   localparam int PRINT_LIMIT  = 40;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   pixel_type req_pixel = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   hsv_type   rsp_pixel;

   pixel_type pending_pixels[$];
   hsv_type   expected_hsv[$];

   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int input_stall_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int holds_done = 0;
   int mode_left = 0;
   int stall_mode = 0;
   int phase_count = 0;

   rgb_to_hsv_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_pixel)
   );

   always #5 clock = ~clock;

   // Integer HSV conversion; red wins ties over green, green over blue
   function automatic hsv_type predict_hsv(pixel_type px);
      int r, g, b, top, bottom, chroma, sat, base, diff, hue_sum;
      hsv_type res;
      r = px.red;
      g = px.green;
      b = px.blue;
      top = r;
      if (g > top) top = g;
      if (b > top) top = b;
      bottom = r;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      chroma = top - bottom;
      res = '0;
      res.brightness = 8'((top + bottom) >> 1);
      // black pixel keeps hue and saturation at zero
      if (top != 0) begin
         sat = (SAT_SCALE * chroma) / top;
         res.saturation = sat[7:0];
         // grey pixel keeps hue at zero
         if (sat != 0) begin
            if (top == r) begin
               base = int'(HUE_BASE_RED);
               diff = g - b;
            end else if (top == g) begin
               base = int'(HUE_BASE_GREEN);
               diff = b - r;
            end else begin
               base = int'(HUE_BASE_BLUE);
               diff = r - g;
            end
            // SV integer division truncates toward zero
            hue_sum = base + (HUE_SPAN * diff) / chroma;
            res.hue = hue_sum[7:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic queue_pixel(int r, int g, int b);
      pixel_type px;
      px.red = 8'(r);
      px.green = 8'(g);
      px.blue = 8'(b);
      pending_pixels.push_back(px);
   endtask

   // Driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      logic      fire;
      logic      load;
      logic      valid_next;
      pixel_type next_pixel;
      fire = 1'b0;
      load = 1'b0;
      valid_next = 1'b0;
      next_pixel = '0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (req_valid && req_stall) input_stall_cycles++;
         if (fire) begin
            expected_hsv.push_back(predict_hsv(req_pixel));
            sent_count++;
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pixels.size() > 0) begin
               next_pixel = pending_pixels.pop_front();
               valid_next = 1'b1;
               load = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end else begin
            valid_next = 1'b1;  // stalled transfer holds its payload
         end
         req_valid <= valid_next;
         if (load) req_pixel <= next_pixel;
      end
   end

   // Output stall pattern, with two long hold-offs to back up the pipeline
   always @(posedge clock) begin
      logic stall_next;
      stall_next = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && ((holds_done == 0 && checked_count >= 300) ||
                                (holds_done == 1 && checked_count >= 1000))) begin
            hold_left = $urandom_range(60, 120);
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase_count++;
            case (stall_mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(0, 99) < 30);
               2: stall_next = ($urandom_range(0, 99) < 75);
               default: stall_next = (phase_count % 4 == 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      hsv_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hsv.size() == 0) begin
            report_mismatch($sformatf("unexpected result h=%0d s=%0d v=%0d",
               rsp_pixel.hue, rsp_pixel.saturation, rsp_pixel.brightness));
         end else begin
            want = expected_hsv.pop_front();
            checked_count++;
            if (rsp_pixel.hue !== want.hue)
               report_mismatch($sformatf("result %0d hue %0d, want %0d",
                  checked_count, rsp_pixel.hue, want.hue));
            if (rsp_pixel.saturation !== want.saturation)
               report_mismatch($sformatf("result %0d saturation %0d, want %0d",
                  checked_count, rsp_pixel.saturation, want.saturation));
            if (rsp_pixel.brightness !== want.brightness)
               report_mismatch($sformatf("result %0d brightness %0d, want %0d",
                  checked_count, rsp_pixel.brightness, want.brightness));
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int kind, a, b, c, lo;
      // extremes, black, white, greys
      queue_pixel(0, 0, 0);
      queue_pixel(255, 255, 255);
      queue_pixel(128, 128, 128);
      queue_pixel(1, 1, 1);
      // primaries, one per hue sector
      queue_pixel(255, 0, 0);
      queue_pixel(0, 255, 0);
      queue_pixel(0, 0, 255);
      // tied maximum: red over green, green over blue, red over blue
      queue_pixel(255, 255, 0);
      queue_pixel(0, 255, 255);
      queue_pixel(255, 0, 255);
      queue_pixel(1, 1, 0);
      queue_pixel(7, 3, 7);
      // negative differences, hue wraps below zero
      queue_pixel(255, 0, 128);
      queue_pixel(255, 0, 1);
      queue_pixel(200, 50, 100);
      // small max and one-step chroma
      queue_pixel(1, 0, 0);
      queue_pixel(0, 1, 1);
      queue_pixel(255, 254, 254);
      queue_pixel(254, 255, 253);
      queue_pixel(200, 100, 50);
      queue_pixel(10, 20, 30);
      queue_pixel(0, 128, 255);

      for (int i = 0; i < RAND_PIXELS; i++) begin
         kind = $urandom_range(0, 99);
         a = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
         c = $urandom_range(0, 255);
         if (kind < 50) begin
            queue_pixel(a, b, c);
         end else if (kind < 70) begin
            // near grey: channels within a few codes
            lo = $urandom_range(0, 250);
            queue_pixel(lo + $urandom_range(0, 5), lo + $urandom_range(0, 5),
                        lo + $urandom_range(0, 5));
         end else if (kind < 85) begin
            // two channels tied
            case ($urandom_range(0, 2))
               0: queue_pixel(a, a, c);
               1: queue_pixel(a, b, b);
               default: queue_pixel(a, b, a);
            endcase
         end else begin
            // channels pinned to the rails
            queue_pixel(($urandom_range(0, 2) == 0) ? a : 255 * $urandom_range(0, 1),
                        ($urandom_range(0, 2) == 0) ? b : 255 * $urandom_range(0, 1),
                        ($urandom_range(0, 2) == 0) ? c : 255 * $urandom_range(0, 1));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() > 0 || req_valid) @(posedge clock);
      while (expected_hsv.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d pixels sent and %0d results checked (directed and random).",
         sent_count, checked_count);
      $display("Input held back for %0d cycles under output stalls and %0d long hold-offs.",
         input_stall_cycles, holds_done);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("Timeout with %0d results still outstanding", expected_hsv.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
